// ----- rtl/laser_line_column_triangulation_defines.svh -----
// Assertion macros for the laser line triangulation checker.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef LASER_LINE_COLUMN_TRIANGULATION_DEFINES_SVH
`define LASER_LINE_COLUMN_TRIANGULATION_DEFINES_SVH

// property checked only outside reset
`define LLCT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked on every edge, reset included
`define LLCT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ----- rtl/llct_pkg.sv -----
// Shared types and constants of the laser line triangulation block.
// No dependencies.
package llct_pkg;

  // laser plane geometry, unsigned, 16 fractional bits (Q8.16; S_Q16 is Q9.16)
  localparam logic [23:0] H_Q16 = 24'd13312983;
  localparam logic [23:0] B_Q16 = 24'd11962941;
  localparam logic [24:0] S_Q16 = 25'd17898254;

  localparam int unsigned JOB_DEPTH = 4;

  typedef enum logic [2:0] {
    REG_THRESHOLD = 3'd0,
    REG_SLICE_POS = 3'd1,
    REG_FOCAL_U   = 3'd2,
    REG_FOCAL_V   = 3'd3,
    REG_CENTER_U  = 3'd4,
    REG_CENTER_V  = 3'd5,
    REG_RADIAL_K1 = 3'd6,
    REG_RADIAL_K2 = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic        [7:0]  threshold;
    logic signed [31:0] slice_position;
    logic        [12:0] focal_u;
    logic        [12:0] focal_v;
    logic        [11:0] center_u;
    logic        [11:0] center_v;
    logic signed [15:0] radial_k1;
    logic signed [15:0] radial_k2;
  } cfg_t;

  // one finished column, front to back
  typedef struct packed {
    logic        hit;
    logic [11:0] col;
    logic [11:0] row;
    logic        fend;
  } job_t;

  typedef struct packed {
    logic               hit;
    logic        [11:0] col;
    logic signed [31:0] wx;
    logic signed [31:0] wy;
    logic signed [31:0] wz;
    logic               last;
  } res_t;

endpackage

// ----- rtl/llct_fifo.sv -----
// Short job queue between the pixel scanner and the triangulation sequencer.
// Uses llct_pkg.
module llct_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  llct_pkg::job_t wdata_i,
  output logic          full_o,
  input  logic          rd_i,
  output logic          valid_o,
  output llct_pkg::job_t rdata_o
);
  import llct_pkg::*;

  localparam int unsigned AW = $clog2(JOB_DEPTH);

  job_t            mem_q [JOB_DEPTH];
  logic [AW-1:0]   wptr_q, rptr_q;
  logic [AW:0]     cnt_q;
  logic            do_wr, do_rd;

  assign full_o  = (cnt_q == (AW+1)'(JOB_DEPTH));
  assign valid_o = (cnt_q != '0);
  assign rdata_o = mem_q[rptr_q];
  assign do_wr   = wr_i && !full_o;
  assign do_rd   = rd_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_wr) wptr_q <= wptr_q + 1'b1;
      if (do_rd) rptr_q <= rptr_q + 1'b1;
      if (do_wr && !do_rd) cnt_q <= cnt_q + 1'b1;
      else if (do_rd && !do_wr) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

// ----- rtl/llct_div.sv -----
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module llct_div #(
  parameter int unsigned DW = 82,
  parameter int unsigned VW = 58
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  logic [DW-1:0] dvd_i,
  input  logic [VW-1:0] dvs_i,
  output logic          done_o,
  output logic [DW-1:0] quo_o
);
  localparam int unsigned CW = $clog2(DW + 1);

  logic [DW-1:0] dvd_q;
  logic [VW-1:0] dvs_q, rem_q;
  logic [CW-1:0] cnt_q;
  logic          busy_q, done_q;
  logic [VW:0]   shifted, diff;
  logic          ge;

  assign shifted = {rem_q, dvd_q[DW-1]};
  assign diff    = shifted - {1'b0, dvs_q};
  assign ge      = (shifted >= {1'b0, dvs_q});
  assign done_o  = done_q;
  assign quo_o   = dvd_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dvd_i;
      dvs_q <= dvs_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[DW-2:0], ge};
      rem_q <= ge ? diff[VW-1:0] : shifted[VW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- rtl/llct_front.sv -----
// Pixel scanner: finds the first lit pixel of each column, emits one job per column.
// Uses llct_pkg.
module llct_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           accept_i,
  input  logic [7:0]     gray_i,
  input  logic [11:0]    column_i,
  input  logic [11:0]    row_i,
  input  logic           column_end_i,
  input  logic           frame_end_i,
  input  logic [7:0]     threshold_i,
  output logic           job_push_o,
  output llct_pkg::job_t job_o
);
  import llct_pkg::*;

  logic        found_q, found_d;
  logic [11:0] row_q, row_d;
  logic        lit, ends;

  assign lit  = gray_i > threshold_i;
  assign ends = column_end_i || frame_end_i;

  always_comb begin
    found_d    = found_q;
    row_d      = row_q;
    job_push_o = 1'b0;
    job_o.hit  = found_q || lit;
    job_o.col  = column_i;
    job_o.row  = found_q ? row_q : row_i;
    job_o.fend = frame_end_i;
    if (accept_i) begin
      if (ends) begin
        job_push_o = 1'b1;
        found_d    = 1'b0;
        row_d      = '0;
      end else if (!found_q && lit) begin
        found_d = 1'b1;
        row_d   = row_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
      row_q   <= '0;
    end else begin
      found_q <= found_d;
      row_q   <= row_d;
    end
  end

endmodule

// ----- rtl/llct_back.sv -----
// Triangulation sequencer: undistorts one column hit and maps it onto the laser plane.
// Uses llct_pkg and llct_div; one shared multiplier, one shared divider.
module llct_back #(
  parameter int unsigned F = 12
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           job_valid_i,
  input  llct_pkg::job_t job_i,
  output logic           job_pop_o,
  input  llct_pkg::cfg_t cfg_i,
  input  logic           res_ready_i,
  output logic           res_push_o,
  output llct_pkg::res_t res_o
);
  import llct_pkg::*;

  localparam int unsigned XNW = F + 14;
  localparam int unsigned R2W = F + 11;
  localparam int unsigned R4W = F + 21;
  localparam int unsigned FCW = F + 26;
  localparam int unsigned PW  = F + 22;
  localparam int unsigned NDW = F + 47;
  localparam int unsigned MA  = F + 24;
  localparam int unsigned MB  = (F + 14 > 26) ? F + 14 : 26;
  localparam int unsigned PRW = MA + MB;
  localparam int unsigned LO  = F + 18;
  localparam int unsigned DW  = F + 70;
  localparam int unsigned VW  = F + 46;

  localparam logic [R2W-1:0]        R2MAX = R2W'(1) << (F + 10);
  localparam logic signed [PRW-1:0] LIM   = PRW'(1) << (F + 20);
  localparam logic [DW-1:0]         TCAP  = DW'(1) << 40;

  typedef enum logic [27:0] {
    ST_IDLE  = 28'd1 << 0,  ST_XDIV  = 28'd1 << 1,  ST_XWAIT = 28'd1 << 2,
    ST_YDIV  = 28'd1 << 3,  ST_YWAIT = 28'd1 << 4,  ST_SQX   = 28'd1 << 5,
    ST_SQY   = 28'd1 << 6,  ST_R2    = 28'd1 << 7,  ST_R4M   = 28'd1 << 8,
    ST_R4    = 28'd1 << 9,  ST_K1    = 28'd1 << 10, ST_K2    = 28'd1 << 11,
    ST_FAC   = 28'd1 << 12, ST_PU    = 28'd1 << 13, ST_PV    = 28'd1 << 14,
    ST_YM    = 28'd1 << 15, ST_WDIV  = 28'd1 << 16, ST_WWAIT = 28'd1 << 17,
    ST_Z1    = 28'd1 << 18, ST_Z2    = 28'd1 << 19, ST_Z3    = 28'd1 << 20,
    ST_Z4    = 28'd1 << 21, ST_Z5    = 28'd1 << 22, ST_Z6    = 28'd1 << 23,
    ST_ZDIV  = 28'd1 << 24, ST_ZWAIT = 28'd1 << 25, ST_EMIT  = 28'd1 << 26,
    ST_Z7    = 28'd1 << 27
  } state_e;

  state_e state_q, state_d;

  logic signed [12:0]    du_q, dv_q;
  logic signed [XNW-1:0] xn_q, yn_q;
  logic [R2W-1:0]        r2_q;
  logic [R4W-1:0]        r4_q;
  logic signed [FCW-1:0] fac_q;
  logic signed [PW-1:0]  pu_q, pv_q;
  logic signed [PRW-1:0] acc_q, p_q;
  logic signed [NDW-1:0] num_q, den_q;
  logic signed [31:0]    wy_q, wz_q;
  logic                  hit_q, fend_q, neg_q;
  logic [11:0]           col_q;

  logic signed [MA-1:0]  mul_a;
  logic signed [MB-1:0]  mul_b;
  logic                  div_start, div_done;
  logic [DW-1:0]         div_dvd, div_quo;
  logic [VW-1:0]         div_dvs;

  logic [12:0]           fu, fv, du_mag, dv_mag;
  logic signed [PW:0]    dneg;
  logic [NDW-1:0]        num_mag, den_mag;
  logic signed [PRW-1:0] sum_ap;
  logic [PRW-1:0]        r2_full;
  logic [40:0]           t41;
  logic signed [42:0]    zsum;

  function automatic logic signed [PW-1:0] clampmag(input logic signed [PRW-1:0] v);
    if (v > LIM) return PW'(LIM);
    if (v < -LIM) return PW'(-LIM);
    return PW'(v);
  endfunction

  // signed round result from magnitude and sign, saturated to 32 bits
  function automatic logic signed [31:0] sat_q(input logic neg, input logic [DW-1:0] q);
    if (!neg) return (q > DW'(32'h7fff_ffff)) ? 32'sh7fff_ffff : 32'(q);
    return (q > DW'(33'h0_8000_0000)) ? -32'sh7fff_ffff - 32'sd1 : -32'(q);
  endfunction

  function automatic logic signed [31:0] sat43(input logic signed [42:0] v);
    if (v > 43'sd2147483647) return 32'sh7fff_ffff;
    if (v < -43'sd2147483648) return -32'sh7fff_ffff - 32'sd1;
    return 32'(v);
  endfunction

  assign fu      = (cfg_i.focal_u == '0) ? 13'd1 : cfg_i.focal_u;
  assign fv      = (cfg_i.focal_v == '0) ? 13'd1 : cfg_i.focal_v;
  assign du_mag  = du_q[12] ? 13'(-du_q) : 13'(du_q);
  assign dv_mag  = dv_q[12] ? 13'(-dv_q) : 13'(dv_q);
  assign dneg    = -(PW+1)'(pv_q);
  assign num_mag = num_q[NDW-1] ? NDW'(-num_q) : NDW'(num_q);
  assign den_mag = den_q[NDW-1] ? NDW'(-den_q) : NDW'(den_q);
  assign sum_ap  = acc_q + p_q;
  assign r2_full = PRW'(sum_ap) >> F;
  assign t41     = (div_quo > TCAP) ? TCAP[40:0] : div_quo[40:0];
  assign zsum    = (num_q[NDW-1] == den_q[NDW-1])
                 ? 43'(signed'({1'b0, H_Q16})) - 43'(signed'({1'b0, t41}))
                 : 43'(signed'({1'b0, H_Q16})) + 43'(signed'({1'b0, t41}));

  llct_div #(.DW(DW), .VW(VW)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .dvd_i   (div_dvd),
    .dvs_i   (div_dvs),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // operand select for the shared multiplier and divider
  always_comb begin
    mul_a     = '0;
    mul_b     = '0;
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = '0;
    case (state_q)
      ST_XDIV: begin
        div_start = 1'b1;
        div_dvd   = (DW'(du_mag) << F) + DW'(fu >> 1);
        div_dvs   = VW'(fu);
      end
      ST_YDIV: begin
        div_start = 1'b1;
        div_dvd   = (DW'(dv_mag) << F) + DW'(fv >> 1);
        div_dvs   = VW'(fv);
      end
      ST_SQX: begin mul_a = MA'(xn_q); mul_b = MB'(xn_q); end
      ST_SQY: begin mul_a = MA'(yn_q); mul_b = MB'(yn_q); end
      ST_R4M: begin
        mul_a = MA'(signed'({1'b0, r2_q}));
        mul_b = MB'(signed'({1'b0, r2_q}));
      end
      ST_K1: begin mul_a = MA'(signed'({1'b0, r2_q})); mul_b = MB'(cfg_i.radial_k1); end
      ST_K2: begin mul_a = MA'(signed'({1'b0, r4_q})); mul_b = MB'(cfg_i.radial_k2); end
      ST_PU: begin mul_a = MA'(fac_q); mul_b = MB'(du_q); end
      ST_PV: begin mul_a = MA'(fac_q); mul_b = MB'(dv_q); end
      ST_YM: begin mul_a = MA'(pu_q); mul_b = MB'(signed'({1'b0, S_Q16})); end
      ST_WDIV: begin
        div_start = 1'b1;
        div_dvd   = DW'(p_q[PRW-1] ? -p_q : p_q) + DW'((VW'(fu) << F) >> 1);
        div_dvs   = VW'(fu) << F;
      end
      ST_Z1: begin mul_a = MA'(signed'({1'b0, H_Q16})); mul_b = MB'(signed'({1'b0, fv})); end
      ST_Z2: begin mul_a = MA'(dneg); mul_b = MB'(signed'({1'b0, B_Q16})); end
      ST_Z3: begin mul_a = MA'(signed'({1'b0, B_Q16})); mul_b = MB'(signed'({1'b0, fv})); end
      ST_Z4: begin mul_a = MA'(dneg); mul_b = MB'(signed'({1'b0, H_Q16})); end
      // B*|num| in two halves: low part first, high part next
      ST_Z6: begin
        mul_a = MA'(signed'({1'b0, num_mag[LO-1:0]}));
        mul_b = MB'(signed'({1'b0, B_Q16}));
      end
      ST_Z7: begin
        mul_a = MA'(signed'({1'b0, num_mag[NDW-1:LO]}));
        mul_b = MB'(signed'({1'b0, B_Q16}));
      end
      ST_ZDIV: begin
        div_start = 1'b1;
        div_dvd   = DW'(acc_q) + (DW'(p_q) << LO) + DW'(den_mag >> 1);
        div_dvs   = VW'(den_mag);
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:  if (job_valid_i) state_d = job_i.hit ? ST_XDIV : ST_EMIT;
      ST_XDIV:  state_d = ST_XWAIT;
      ST_XWAIT: if (div_done) state_d = ST_YDIV;
      ST_YDIV:  state_d = ST_YWAIT;
      ST_YWAIT: if (div_done) state_d = ST_SQX;
      ST_SQX:   state_d = ST_SQY;
      ST_SQY:   state_d = ST_R2;
      ST_R2:    state_d = ST_R4M;
      ST_R4M:   state_d = ST_R4;
      ST_R4:    state_d = ST_K1;
      ST_K1:    state_d = ST_K2;
      ST_K2:    state_d = ST_FAC;
      ST_FAC:   state_d = ST_PU;
      ST_PU:    state_d = ST_PV;
      ST_PV:    state_d = ST_YM;
      ST_YM:    state_d = ST_WDIV;
      ST_WDIV:  state_d = ST_WWAIT;
      ST_WWAIT: if (div_done) state_d = ST_Z1;
      ST_Z1:    state_d = ST_Z2;
      ST_Z2:    state_d = ST_Z3;
      ST_Z3:    state_d = ST_Z4;
      ST_Z4:    state_d = ST_Z5;
      ST_Z5:    state_d = ST_Z6;
      ST_Z6:    state_d = (den_q == '0) ? ST_EMIT : ST_Z7;
      ST_Z7:    state_d = ST_ZDIV;
      ST_ZDIV:  state_d = ST_ZWAIT;
      ST_ZWAIT: if (div_done) state_d = ST_EMIT;
      ST_EMIT:  if (res_ready_i) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  assign job_pop_o  = (state_q == ST_IDLE) && job_valid_i;
  assign res_push_o = (state_q == ST_EMIT) && res_ready_i;

  always_comb begin
    res_o.hit  = hit_q;
    res_o.col  = col_q;
    res_o.wx   = cfg_i.slice_position;
    res_o.wy   = wy_q;
    res_o.wz   = wz_q;
    res_o.last = fend_q;
  end

  // datapath
  always_ff @(posedge clk_i) begin
    p_q <= mul_a * mul_b;
    case (state_q)
      ST_IDLE: begin
        hit_q  <= job_i.hit;
        col_q  <= job_i.col;
        fend_q <= job_i.fend;
        du_q   <= signed'({1'b0, job_i.col}) - signed'({1'b0, cfg_i.center_u});
        dv_q   <= signed'({1'b0, job_i.row}) - signed'({1'b0, cfg_i.center_v});
        wy_q   <= '0;
        wz_q   <= '0;
      end
      ST_XWAIT: if (div_done) xn_q <= du_q[12] ? -XNW'(div_quo) : XNW'(div_quo);
      ST_YWAIT: if (div_done) yn_q <= dv_q[12] ? -XNW'(div_quo) : XNW'(div_quo);
      ST_SQY:   acc_q <= p_q;
      ST_R2:    r2_q <= (r2_full > PRW'(R2MAX)) ? R2MAX : R2W'(r2_full);
      ST_R4:    r4_q <= R4W'(p_q >>> F);
      ST_K2:    acc_q <= p_q;
      ST_FAC:   fac_q <= (FCW'(1) << F) + FCW'(sum_ap >>> 14);
      ST_PV:    pu_q <= clampmag(p_q);
      ST_YM:    pv_q <= clampmag(p_q);
      ST_WDIV:  neg_q <= p_q[PRW-1];
      ST_WWAIT: if (div_done) wy_q <= sat_q(neg_q, div_quo);
      ST_Z2:    acc_q <= p_q <<< F;
      ST_Z3:    num_q <= NDW'(acc_q - p_q);
      ST_Z4:    acc_q <= p_q <<< F;
      ST_Z5:    den_q <= NDW'(sum_ap);
      ST_Z6: begin
        // zero denominator: saturate against the sign of the numerator
        if (den_q == '0) wz_q <= (num_q > 0) ? -32'sh7fff_ffff - 32'sd1 : 32'sh7fff_ffff;
      end
      ST_Z7:    acc_q <= p_q;
      ST_ZWAIT: if (div_done) wz_q <= sat43(zsum);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

endmodule

// ----- rtl/laser_line_column_triangulation.sv -----
// Laser line column triangulation, top level.
// Pixels stream in at one per cycle while the job queue has room. Each column passes the
// job queue, the sequencer and the output register; a hit also uses the shared divider.
// The 4-deep job queue absorbs short bursts; sustained rate is one column per sequencer pass.
// Async active-low reset clears control, the queues and the config registers to defaults.
module laser_line_column_triangulation #(
  parameter int unsigned COORD_BITS = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // pixel queue side
  input  logic               push_i,
  output logic               full_o,
  input  logic [7:0]         gray_i,
  input  logic [11:0]        column_i,
  input  logic [11:0]        row_i,
  input  logic               column_end_i,
  input  logic               frame_end_i,
  // result queue side
  output logic               empty_o,
  input  logic               pop_i,
  output logic               hit_o,
  output logic [11:0]        column_index_o,
  output logic signed [31:0] world_x_o,
  output logic signed [31:0] world_y_o,
  output logic signed [31:0] world_z_o,
  output logic               last_of_frame_o,
  // configuration writes
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i
);
  import llct_pkg::*;

  cfg_t cfg_q;
  job_t front_job, back_job;
  res_t back_res, res_q;
  logic pix_accept, job_push, job_full, job_valid, job_pop;
  logic res_push, res_valid_q, res_slot_free;

  // A pixel transaction completes when the job queue has room; every pixel of
  // a column waits on the same condition so the scanner never drops an end pixel.
  assign full_o     = job_full;
  assign pix_accept = push_i && !job_full;

  // Config registers; software must write them only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold      <= 8'd45;
      cfg_q.slice_position <= '0;
      cfg_q.focal_u        <= 13'd1388;
      cfg_q.focal_v        <= 13'd1388;
      cfg_q.center_u       <= 12'd970;
      cfg_q.center_v       <= 12'd553;
      cfg_q.radial_k1      <= 16'sd1671;
      cfg_q.radial_k2      <= -16'sd2785;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        REG_THRESHOLD: cfg_q.threshold      <= cfg_data_i[7:0];
        REG_SLICE_POS: cfg_q.slice_position <= signed'(cfg_data_i);
        REG_FOCAL_U:   cfg_q.focal_u        <= cfg_data_i[12:0];
        REG_FOCAL_V:   cfg_q.focal_v        <= cfg_data_i[12:0];
        REG_CENTER_U:  cfg_q.center_u       <= cfg_data_i[11:0];
        REG_CENTER_V:  cfg_q.center_v       <= cfg_data_i[11:0];
        REG_RADIAL_K1: cfg_q.radial_k1      <= signed'(cfg_data_i[15:0]);
        REG_RADIAL_K2: cfg_q.radial_k2      <= signed'(cfg_data_i[15:0]);
        default: ;
      endcase
    end
  end

  // Front: first-lit-pixel scan, one pixel per cycle while the job queue has room.
  llct_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (pix_accept),
    .gray_i       (gray_i),
    .column_i     (column_i),
    .row_i        (row_i),
    .column_end_i (column_end_i),
    .frame_end_i  (frame_end_i),
    .threshold_i  (cfg_q.threshold),
    .job_push_o   (job_push),
    .job_o        (front_job)
  );

  // Decoupling queue: one entry per finished column.
  llct_fifo u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (job_push),
    .wdata_i (front_job),
    .full_o  (job_full),
    .rd_i    (job_pop),
    .valid_o (job_valid),
    .rdata_o (back_job)
  );

  // Back: undistort and triangulate, one column at a time.
  llct_back #(.F(COORD_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (back_job),
    .job_pop_o   (job_pop),
    .cfg_i       (cfg_q),
    .res_ready_i (res_slot_free),
    .res_push_o  (res_push),
    .res_o       (back_res)
  );

  // Output register: the result waits here so the sequencer can start the next
  // column; it is refilled in the same cycle the consumer pops it.
  assign res_slot_free = !res_valid_q || pop_i;

  always_ff @(posedge clk_i) begin
    if (res_push) res_q <= back_res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_push) begin
      res_valid_q <= 1'b1;
    end else if (pop_i) begin
      res_valid_q <= 1'b0;
    end
  end

  assign empty_o         = !res_valid_q;
  assign hit_o           = res_q.hit;
  assign column_index_o  = res_q.col;
  assign world_x_o       = res_q.wx;
  assign world_y_o       = res_q.wy;
  assign world_z_o       = res_q.wz;
  assign last_of_frame_o = res_q.last;

endmodule

// ----- rtl/llct_checker.sv -----
// Port-level checker for laser_line_column_triangulation, bound to the top level.
// Uses the assertion macros of laser_line_column_triangulation_defines.svh.
`include "laser_line_column_triangulation_defines.svh"

module llct_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty_o,
  input logic               pop_i,
  input logic               hit_o,
  input logic [11:0]        column_index_o,
  input logic signed [31:0] world_y_o,
  input logic signed [31:0] world_z_o
);

  `LLCT_ASSERT_ALWAYS(a_empty_in_reset, !rst_ni |=> empty_o, "result shown during reset")
  `LLCT_ASSERT(a_held_result, !empty_o && !pop_i |=> !empty_o && $stable(column_index_o) && $stable(world_z_o), "waiting result changed")
  `LLCT_ASSERT(a_miss_zero, !empty_o && !hit_o |-> world_y_o == 0 && world_z_o == 0, "no-hit result with nonzero coordinates")

endmodule

bind laser_line_column_triangulation llct_checker u_llct_checker (.*);
